### src/mid_pkg.sv
// ----------------------------------------------------------------------------
// mid_pkg
// Shared kinds, result bundle and helper functions for the modular integer
// decoder: payload placement with overflow detection and offset saturation.
// ----------------------------------------------------------------------------
package mid_pkg;

    // value kinds, same code on command and on the reported kind
    localparam logic [1:0] KIND_UCHAR = 2'd0;
    localparam logic [1:0] KIND_SCHAR = 2'd1;
    localparam logic [1:0] KIND_SHORT = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    // payload group sizes and offset ceiling
    localparam logic [4:0] STEP_CHAR  = 5'd7;
    localparam logic [4:0] STEP_SHORT = 5'd15;
    localparam logic [6:0] OFF_MAX    = 7'd127;

    // result of one decoded value
    typedef struct packed {
        logic [63:0] value_bits;
        logic [1:0]  kind;
        logic        overflow;
    } result_t;

    // placed payload and overflow flag
    typedef struct packed {
        logic [63:0] value;
        logic        ovf;
    } place_t;

    // place a payload of up to 15 bits at an offset within a 64- or 32-bit result
    function automatic place_t mid_place(input logic [14:0] payload,
                                         input logic [6:0]  off,
                                         input logic        wide64);
        place_t      res;
        logic [78:0] shifted;
        shifted = {64'd0, payload} << off[5:0];
        res.value = 64'd0;
        res.ovf   = 1'b0;
        if (wide64) begin
            if (off[6]) begin
                res.ovf = (payload != 15'd0);
            end else begin
                res.value = shifted[63:0];
                res.ovf   = (shifted[78:64] != 15'd0);
            end
        end else begin
            if (off >= 7'd32) begin
                res.ovf = (payload != 15'd0);
            end else begin
                res.value = {32'd0, shifted[31:0]};
                res.ovf   = (shifted[78:32] != 47'd0);
            end
        end
        return res;
    endfunction

    // advance the bit offset, saturating at its ceiling
    function automatic logic [6:0] mid_advance(input logic [6:0] off,
                                               input logic [4:0] step);
        logic [7:0] sum;
        sum = {1'b0, off} + {3'd0, step};
        return (sum > {1'b0, OFF_MAX}) ? OFF_MAX : sum[6:0];
    endfunction

    // sign-extend a 32-bit value to 64 bits
    function automatic logic [63:0] mid_sext32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

### src/mid_decode.sv
// ----------------------------------------------------------------------------
// mid_decode
// Value state registers and the single-pass update for one byte: places the
// payload group, tracks pair phase and overflow, and flags the ending byte.
// ----------------------------------------------------------------------------
module mid_decode (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step,
    input  logic [1:0]      command,
    input  logic [7:0]      data_byte,
    output logic            done,
    output mid_pkg::result_t result
);
    import mid_pkg::*;

    logic [63:0] acc_reg,   acc_next;
    logic [6:0]  off_reg,   off_next;
    logic        in_value_reg, in_value_next;
    logic [1:0]  kind_reg,  kind_next;
    logic [7:0]  low_reg,   low_next;
    logic        phase_reg, phase_next;
    logic        ovf_reg,   ovf_next;

    logic [63:0] acc_cur;
    logic [6:0]  off_cur;
    logic [7:0]  low_cur;
    logic        phase_cur;
    logic        ovf_cur;
    place_t      placed;
    logic [31:0] mag;

    // byte update, with fresh state at the start of a value
    always_comb begin
        if (in_value_reg) begin
            kind_next = kind_reg;
            acc_cur   = acc_reg;
            off_cur   = off_reg;
            low_cur   = low_reg;
            phase_cur = phase_reg;
            ovf_cur   = ovf_reg;
        end else begin
            kind_next = (command == KIND_RSVD) ? KIND_UCHAR : command;
            acc_cur   = 64'd0;
            off_cur   = 7'd0;
            low_cur   = 8'd0;
            phase_cur = 1'b0;
            ovf_cur   = 1'b0;
        end

        acc_next          = acc_cur;
        off_next          = off_cur;
        low_next          = low_cur;
        phase_next        = phase_cur;
        ovf_next          = ovf_cur;
        done              = 1'b0;
        placed            = '0;
        mag               = 32'd0;
        result.value_bits = 64'd0;

        case (kind_next)
            KIND_UCHAR: begin
                placed            = mid_place({8'd0, data_byte[6:0]}, off_cur, 1'b1);
                acc_next          = acc_cur | placed.value;
                ovf_next          = ovf_cur | placed.ovf;
                off_next          = mid_advance(off_cur, STEP_CHAR);
                done              = ~data_byte[7];
                result.value_bits = acc_next;
            end
            KIND_SCHAR: begin
                if (data_byte[7]) begin
                    placed   = mid_place({8'd0, data_byte[6:0]}, off_cur, 1'b0);
                    acc_next = acc_cur | placed.value;
                    ovf_next = ovf_cur | placed.ovf;
                    off_next = mid_advance(off_cur, STEP_CHAR);
                end else begin
                    // final byte: six bits, bit 6 negates modulo 2^32
                    placed   = mid_place({9'd0, data_byte[5:0]}, off_cur, 1'b0);
                    ovf_next = ovf_cur | placed.ovf;
                    mag      = acc_cur[31:0] | placed.value[31:0];
                    if (data_byte[6]) begin
                        mag = 32'd0 - mag;
                    end
                    acc_next          = {32'd0, mag};
                    done              = 1'b1;
                    result.value_bits = mid_sext32(mag);
                end
            end
            KIND_SHORT: begin
                if (!phase_cur) begin
                    low_next   = data_byte;
                    phase_next = 1'b1;
                end else begin
                    placed            = mid_place({data_byte[6:0], low_cur}, off_cur, 1'b0);
                    acc_next          = acc_cur | placed.value;
                    ovf_next          = ovf_cur | placed.ovf;
                    off_next          = mid_advance(off_cur, STEP_SHORT);
                    phase_next        = 1'b0;
                    done              = ~data_byte[7];
                    result.value_bits = mid_sext32(acc_next[31:0]);
                end
            end
            default: begin
                done = 1'b0;
            end
        endcase

        in_value_next   = ~done;
        result.kind     = kind_next;
        result.overflow = ovf_next;
    end

    // value state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= 64'd0;
            off_reg      <= 7'd0;
            in_value_reg <= 1'b0;
            kind_reg     <= KIND_UCHAR;
            low_reg      <= 8'd0;
            phase_reg    <= 1'b0;
            ovf_reg      <= 1'b0;
        end else if (step) begin
            acc_reg      <= acc_next;
            off_reg      <= off_next;
            in_value_reg <= in_value_next;
            kind_reg     <= kind_next;
            low_reg      <= low_next;
            phase_reg    <= phase_next;
            ovf_reg      <= ovf_next;
        end
    end

endmodule

### src/modular_integer_decoder.sv
// ----------------------------------------------------------------------------
// modular_integer_decoder
// Stream decoder for modular char (unsigned, signed) and modular short
// variable-length integers, one encoded byte per transaction.
// ----------------------------------------------------------------------------
// usage
//   slave side takes one byte per transaction: s_tdata carries the byte and
//   s_tuser the kind of value, sampled only on the first byte of a value
//   master side gives one transaction per finished value: m_tdata carries the
//   64-bit value (signed kinds sign-extended from 32 bits), m_tuser the kind
//   and an overflow flag for dropped nonzero payload bits
//   bytes that do not end a value give no transaction
//   an ending byte is held in the input register after the slave-side
//   transaction, and the byte update then loads its result into the result
//   register, which drives the master side
//   throughput: one byte per cycle while the result register is free or
//   being taken
//   a stall on m_tready holds the result; further bytes that end no value
//   still go through, and an ending byte waits in the input register
//   reset (aresetn low, synchronous) empties both registers and returns the
//   decoder to the start of a value
// ----------------------------------------------------------------------------
module modular_integer_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [63:0] value_bits
    output logic [2:0]  m_tuser    // [1:0] kind, [2] overflow
);
    import mid_pkg::*;

    logic       in_valid_reg;
    logic [1:0] in_cmd_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       done;
    logic       advance;
    result_t    result;

    mid_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .command   (in_cmd_reg),
        .data_byte (in_byte_reg),
        .done      (done),
        .result    (result)
    );

    // held byte moves on unless it ends a value and the result slot is full
    assign advance  = in_valid_reg & (~done | ~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg  <= s_tuser;
            in_byte_reg <= s_tdata;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && done) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && done) begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.value_bits;
    assign m_tuser  = {out_reg.overflow, out_reg.kind};

endmodule

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the modular integer decoder. Byte transactions are
// fed with random gaps while the result side stalls at random. Every accepted
// byte runs through a local decoder model, and each finished value is queued
// and compared field by field with the next result transaction.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mid_pkg::*;

    localparam int RANDOM_PER_PHASE = 370;
    localparam int HOLD_CYCLES      = 300;
    localparam int LIMIT_CYCLES     = 4000;
    localparam int TAIL_CYCLES      = 10;
    localparam int N_DIRECTED       = 29;
    localparam logic [63:0] ALL_ONES = '1;

    // one row of directed stimulus, the expectation only where it is obvious
    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  data;
        int          reps;
        bit          typed;
        logic [63:0] value;
        logic [1:0]  kind;
        bit          ovf;
    } stim_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic [1:0]  s_tuser  = KIND_UCHAR;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;
    logic [2:0]  m_tuser;

    // decoder model state
    logic [63:0] acc_bits;
    logic [6:0]  next_off;
    bit          mid_value;
    logic [1:0]  cur_kind;
    logic [7:0]  low_byte;
    bit          second_byte;
    bit          dropped;

    result_t     pending_values[$];
    int          err_cnt;
    int          send_idle;
    int          stall_pct;
    int          phase_no;
    int          idle_cycles;
    logic        hold_off = 1'b0;

    modular_integer_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // put a payload group at the current offset, noting any dropped ones
    function automatic logic [63:0] deposit(input logic [14:0] payload,
                                            input bit full_width);
        logic [142:0] wide;
        wide = {128'd0, payload} << next_off;
        if (full_width) begin
            if (wide[142:64] != '0) dropped = 1'b1;
            return wide[63:0];
        end
        if (wide[142:32] != '0) dropped = 1'b1;
        return {32'd0, wide[31:0]};
    endfunction

    // offset moves on by one group and sticks at its ceiling
    task automatic step_offset(input logic [4:0] n);
        if ({1'b0, next_off} + {3'd0, n} > {1'b0, OFF_MAX}) next_off = OFF_MAX;
        else next_off = next_off + 7'(n);
    endtask

    // decode one byte; done is set when it closes a value
    task automatic decode_byte(input logic [1:0] cmd, input logic [7:0] b,
                               output bit done, output result_t res);
        logic [63:0] part;
        logic [31:0] mag;
        done = 1'b0;
        res  = '0;
        if (!mid_value) begin
            mid_value   = 1'b1;
            cur_kind    = (cmd == KIND_RSVD) ? KIND_UCHAR : cmd;
            acc_bits    = '0;
            next_off    = '0;
            low_byte    = '0;
            second_byte = 1'b0;
            dropped     = 1'b0;
        end
        case (cur_kind)
            KIND_SCHAR: begin
                if (b[7]) begin
                    acc_bits = acc_bits | deposit({8'd0, b[6:0]}, 1'b0);
                    step_offset(STEP_CHAR);
                end else begin
                    // last byte: six bits of magnitude, bit 6 flips the sign
                    part = deposit({9'd0, b[5:0]}, 1'b0);
                    mag  = acc_bits[31:0] | part[31:0];
                    if (b[6]) mag = -mag;
                    acc_bits = {32'd0, mag};
                    res.value_bits = {{32{mag[31]}}, mag};
                    done = 1'b1;
                end
            end
            KIND_SHORT: begin
                if (!second_byte) begin
                    low_byte    = b;
                    second_byte = 1'b1;
                end else begin
                    acc_bits = acc_bits | deposit({b[6:0], low_byte}, 1'b0);
                    step_offset(STEP_SHORT);
                    second_byte = 1'b0;
                    if (!b[7]) begin
                        res.value_bits = {{32{acc_bits[31]}}, acc_bits[31:0]};
                        done = 1'b1;
                    end
                end
            end
            default: begin
                acc_bits = acc_bits | deposit({8'd0, b[6:0]}, 1'b1);
                step_offset(STEP_CHAR);
                if (!b[7]) begin
                    res.value_bits = acc_bits;
                    done = 1'b1;
                end
            end
        endcase
        if (done) begin
            res.kind     = cur_kind;
            res.overflow = dropped;
            mid_value    = 1'b0;
        end
    endtask

    // offer one byte, wait for the transaction, then queue what it gives
    task automatic send_byte(input logic [1:0] cmd, input logic [7:0] b,
                             input bit typed, input result_t typed_res);
        bit      done;
        result_t res;
        while (send_idle != 0 && $urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= cmd;
        do @(posedge aclk); while (!s_tready);
        decode_byte(cmd, b, done, res);
        if (typed) pending_values.push_back(typed_res);
        else if (done) pending_values.push_back(res);
    endtask

    // one random value, mostly well formed, sometimes loose bytes
    task automatic send_value(output int n);
        logic [1:0] kind;
        logic [7:0] b;
        int         len;
        kind = 2'($urandom_range(3));
        n    = 0;
        if ($urandom_range(9) == 0) begin
            len = $urandom_range(1, 4);
            for (int i = 0; i < len; i++) begin
                send_byte(2'($urandom_range(3)), 8'($urandom), 1'b0, '0);
                n++;
            end
        end else if (kind == KIND_SHORT) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2);
            for (int i = 0; i < len; i++) begin
                send_byte(n == 0 ? kind : 2'($urandom_range(3)), 8'($urandom),
                          1'b0, '0);
                b    = 8'($urandom);
                b[7] = (i != len - 1);
                send_byte(2'($urandom_range(3)), b, 1'b0, '0);
                n += 2;
            end
        end else begin
            len = ($urandom_range(7) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3);
            for (int i = 0; i < len; i++) begin
                b    = 8'($urandom);
                b[7] = (i != len - 1);
                send_byte(n == 0 ? kind : 2'($urandom_range(3)), b, 1'b0, '0);
                n++;
            end
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("ERROR at %0t: %s", $realtime, what);
        err_cnt++;
    endtask

    // result side readiness, random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
        end
    end

    // long hold-off early in the first random phase so the input backs up
    initial begin
        wait (phase_no == 1);
        repeat (30) @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // compare each result transaction with the oldest expected value
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_values.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h kind %0d ovf %0b",
                                          m_tdata, m_tuser[1:0], m_tuser[2]));
            end else begin
                want = pending_values.pop_front();
                if (m_tdata !== want.value_bits)
                    report_mismatch($sformatf("value %h, wanted %h",
                                              m_tdata, want.value_bits));
                if (m_tuser[1:0] !== want.kind)
                    report_mismatch($sformatf("kind %0d, wanted %0d",
                                              m_tuser[1:0], want.kind));
                if (m_tuser[2] !== want.overflow)
                    report_mismatch($sformatf("overflow %0b, wanted %0b",
                                              m_tuser[2], want.overflow));
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= LIMIT_CYCLES) begin
            $display("testbench: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // directed values then four random phases
    initial begin
        stim_row_t directed [N_DIRECTED] = '{
            '{KIND_UCHAR, 8'h00,  1, 1'b1, 64'd0,     KIND_UCHAR, 1'b0},
            '{KIND_UCHAR, 8'h7F,  1, 1'b1, 64'd127,   KIND_UCHAR, 1'b0},
            '{KIND_RSVD,  8'h05,  1, 1'b1, 64'd5,     KIND_UCHAR, 1'b0},
            '{KIND_UCHAR, 8'hFF,  1, 1'b0, 64'd0,     KIND_UCHAR, 1'b0},
            '{KIND_SCHAR, 8'h01,  1, 1'b1, 64'hFF,    KIND_UCHAR, 1'b0},
            '{KIND_SCHAR, 8'h3F,  1, 1'b1, 64'd63,    KIND_SCHAR, 1'b0},
            '{KIND_SCHAR, 8'h7F,  1, 1'b1, 64'hFFFF_FFFF_FFFF_FFC1, KIND_SCHAR, 1'b0},
            '{KIND_SCHAR, 8'h40,  1, 1'b1, 64'd0,     KIND_SCHAR, 1'b0},
            '{KIND_SHORT, 8'hFF,  1, 1'b0, 64'd0,     KIND_UCHAR, 1'b0},
            '{KIND_SHORT, 8'h7F,  1, 1'b1, 64'd32767, KIND_SHORT, 1'b0},
            '{KIND_SHORT, 8'h34,  1, 1'b0, 64'd0,     KIND_UCHAR, 1'b0},
            '{KIND_UCHAR, 8'h12,  1, 1'b1, 64'h1234,  KIND_SHORT, 1'b0},
            '{KIND_UCHAR, 8'hFF,  9, 1'b0, 64'd0,     KIND_UCHAR, 1'b0},
            '{KIND_UCHAR, 8'h01,  1, 1'b1, ALL_ONES,  KIND_UCHAR, 1'b0},
            '{KIND_UCHAR, 8'hFF,  9, 1'b0, 64'd0,     KIND_UCHAR, 1'b0},
            '{KIND_UCHAR, 8'h03,  1, 1'b1, ALL_ONES,  KIND_UCHAR, 1'b1},
            '{KIND_UCHAR, 8'hFF, 19, 1'b0, 64'd0,     KIND_UCHAR, 1'b0},
            '{KIND_UCHAR, 8'h00,  1, 1'b1, ALL_ONES,  KIND_UCHAR, 1'b1},
            '{KIND_SCHAR, 8'hFF,  5, 1'b0, 64'd0,     KIND_UCHAR, 1'b0},
            '{KIND_SCHAR, 8'h7F,  1, 1'b0, 64'd0,     KIND_UCHAR, 1'b0},
            '{KIND_SCHAR, 8'h80,  4, 1'b0, 64'd0,     KIND_UCHAR, 1'b0},
            '{KIND_SCHAR, 8'h48,  1, 1'b0, 64'd0,     KIND_UCHAR, 1'b0},
            '{KIND_SHORT, 8'hFF,  4, 1'b0, 64'd0,     KIND_UCHAR, 1'b0},
            '{KIND_SHORT, 8'h03,  1, 1'b0, 64'd0,     KIND_UCHAR, 1'b0},
            '{KIND_SHORT, 8'h00,  1, 1'b0, 64'd0,     KIND_UCHAR, 1'b0},
            '{KIND_SHORT, 8'hFF,  6, 1'b0, 64'd0,     KIND_UCHAR, 1'b0},
            '{KIND_SHORT, 8'h00,  2, 1'b0, 64'd0,     KIND_UCHAR, 1'b0},
            '{KIND_RSVD,  8'h81,  1, 1'b0, 64'd0,     KIND_UCHAR, 1'b0},
            '{KIND_SHORT, 8'h7F,  1, 1'b0, 64'd0,     KIND_UCHAR, 1'b0}
        };
        int      idle_plan  [4] = '{0, 72, 0, 23};
        int      stall_plan [4] = '{0, 0, 72, 23};
        int      sent;
        int      n;
        result_t typed_res;

        err_cnt   = 0;
        send_idle = 0;
        stall_pct = 0;
        phase_no  = 0;
        mid_value = 1'b0;

        // hold reset, then release it
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table, the typed rows check the last byte of the row
        foreach (directed[i]) begin
            typed_res.value_bits = directed[i].value;
            typed_res.kind       = directed[i].kind;
            typed_res.overflow   = directed[i].ovf;
            for (int r = 0; r < directed[i].reps; r++)
                send_byte(directed[i].cmd, directed[i].data,
                          directed[i].typed && (r == directed[i].reps - 1), typed_res);
        end

        // random values under each idling and stall plan
        for (int p = 0; p < 4; p++) begin
            send_idle = idle_plan[p];
            stall_pct = stall_plan[p];
            phase_no  = p + 1;
            sent      = 0;
            while (sent < RANDOM_PER_PHASE) begin
                send_value(n);
                sent += n;
            end
        end
        s_tvalid <= 1'b0;

        // drain, then a short tail to catch stray results
        while (pending_values.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
